// ===== rtl/swmm_pkg.sv =====
package swmm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CNT_W    = 9;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

endpackage

// ===== rtl/swmm_in_if.sv =====
interface swmm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic signed [swmm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink   (input valid, input func, input sample, output ready);
endinterface

// ===== rtl/swmm_out_if.sv =====
interface swmm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swmm_pkg::SAMPLE_W-1:0] newest;
  logic signed [swmm_pkg::SAMPLE_W-1:0] window_min;
  logic signed [swmm_pkg::SAMPLE_W-1:0] window_max;
  logic        [swmm_pkg::CNT_W-1:0]    fill_level;

  modport source (output valid, output newest, output window_min, output window_max,
                  output fill_level, input ready);
  modport sink   (input valid, input newest, input window_min, input window_max,
                  input fill_level, output ready);
endinterface

// ===== rtl/swmm_cfg_if.sv =====
interface swmm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [swmm_pkg::CNT_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sliding_window_min_max_unit.sv =====
// Sliding window minimum and maximum over signed Q8.8 samples.
// cfg_i writes window_size, the number of most recent samples kept; it is
// always ready and should be written only while no word is in flight.
// in_i takes one word at a time: func selects add sample or clear window.
// out_o returns one word per input word: newest sample, window minimum,
// window maximum and fill level; all three values read zero when empty.
// An add stores the sample in a single-port circular store and then reads the
// other kept entries back one per cycle through one comparator pair. An add
// that keeps samples passes through the scan state and then the done state,
// which loads the output register; a clear or an add into a zero window goes
// straight to the done state.
// in_i.ready is high only while the sequencer is idle; it rises together with
// out_o.valid when the output register is free, so a word is accepted only once
// the result of the one before has reached the output register. A finished
// result sits in the output register until taken; the next word may be accepted
// and processed meanwhile, and its result waits until the register frees up.
// Reset empties the window, sets window_size to zero and drops any pending
// result; the store contents are not cleared, since only written entries are
// ever counted as kept.
module sliding_window_min_max_unit #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swmm_cfg_if.sink   cfg_i,
  swmm_in_if.sink    in_i,
  swmm_out_if.source out_o
);

  localparam int unsigned CW       = swmm_pkg::CNT_W;
  localparam int unsigned SW       = swmm_pkg::SAMPLE_W;
  localparam int unsigned PTR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned MAX_CLIP = (MAX_WINDOW > 511) ? 511 : MAX_WINDOW;
  localparam logic [CW-1:0]    MAX_CLIP_W = CW'(MAX_CLIP);
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(MAX_WINDOW - 1);

  function automatic logic [CW-1:0] clip_win(input logic [CW-1:0] w);
    return (w > MAX_CLIP_W) ? MAX_CLIP_W : w;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  swmm_pkg::state_e state_q;

  logic [PTR_W-1:0]     ptr_q;
  logic [PTR_W-1:0]     rd_ptr_q;
  logic [CW-1:0]        kept_q;
  logic [CW-1:0]        ws_q;
  logic [CW-1:0]        issue_q;
  logic                 rvld_q;
  logic signed [SW-1:0] rdata_q;
  logic signed [SW-1:0] low_q;
  logic signed [SW-1:0] high_q;
  logic signed [SW-1:0] newest_q;

  logic                 out_valid_q;
  logic signed [SW-1:0] out_newest_q;
  logic signed [SW-1:0] out_min_q;
  logic signed [SW-1:0] out_max_q;
  logic [CW-1:0]        out_fill_q;

  logic signed [SW-1:0] store [MAX_WINDOW];

  logic             in_fire;
  logic             cfg_fire;
  logic             out_fire;
  logic             mem_we;
  logic             mem_re;
  logic [CW:0]      kept_inc;
  logic [CW-1:0]    eff_cur;
  logic [CW-1:0]    eff_cfg;
  logic [CW-1:0]    kept_add;
  logic [PTR_W-1:0] ptr_nxt;

  assign in_i.ready  = (state_q == swmm_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid & in_i.ready;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;
  assign out_fire    = out_valid_q & out_o.ready;

  assign eff_cur  = clip_win(ws_q);
  assign eff_cfg  = clip_win(cfg_i.data);
  assign kept_inc = {1'b0, kept_q} + 1'b1;
  assign kept_add = (kept_inc > {1'b0, eff_cur}) ? eff_cur : kept_inc[CW-1:0];
  assign ptr_nxt  = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;

  assign mem_we = in_fire && (in_i.func == swmm_pkg::FUNC_ADD);
  assign mem_re = (state_q == swmm_pkg::ST_SCAN) && (issue_q != '0);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[ptr_nxt] <= in_i.sample;
    end
    if (mem_re) begin
      rdata_q <= store[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swmm_pkg::ST_IDLE;
      ptr_q       <= '0;
      rd_ptr_q    <= '0;
      kept_q      <= '0;
      ws_q        <= '0;
      issue_q     <= '0;
      rvld_q      <= 1'b0;
      low_q       <= '0;
      high_q      <= '0;
      newest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        ws_q <= cfg_i.data;
        // Shrinking the window drops the oldest entries at once.
        if (kept_q > eff_cfg) begin
          kept_q <= eff_cfg;
        end
      end
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        swmm_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_i.func == swmm_pkg::FUNC_CLEAR) begin
              kept_q   <= '0;
              low_q    <= '0;
              high_q   <= '0;
              newest_q <= '0;
              state_q  <= swmm_pkg::ST_DONE;
            end else begin
              ptr_q    <= ptr_nxt;
              kept_q   <= kept_add;
              // The slot before the new one is the previous newest sample.
              rd_ptr_q <= ptr_q;
              if (kept_add == '0) begin
                low_q    <= '0;
                high_q   <= '0;
                newest_q <= '0;
                state_q  <= swmm_pkg::ST_DONE;
              end else begin
                low_q    <= in_i.sample;
                high_q   <= in_i.sample;
                newest_q <= in_i.sample;
                issue_q  <= kept_add - 1'b1;
                state_q  <= swmm_pkg::ST_SCAN;
              end
            end
          end
        end
        swmm_pkg::ST_SCAN: begin
          rvld_q <= (issue_q != '0);
          if (issue_q != '0) begin
            rd_ptr_q <= ptr_prev(rd_ptr_q);
            issue_q  <= issue_q - 1'b1;
          end
          if (rvld_q) begin
            if (rdata_q < low_q) begin
              low_q <= rdata_q;
            end
            if (rdata_q > high_q) begin
              high_q <= rdata_q;
            end
          end
          if ((issue_q == '0) && !rvld_q) begin
            state_q <= swmm_pkg::ST_DONE;
          end
        end
        swmm_pkg::ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            state_q     <= swmm_pkg::ST_IDLE;
          end
        end
        default: begin
          state_q <= swmm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == swmm_pkg::ST_DONE) && (!out_valid_q || out_o.ready)) begin
      out_newest_q <= newest_q;
      out_min_q    <= low_q;
      out_max_q    <= high_q;
      out_fill_q   <= kept_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.newest     = out_newest_q;
  assign out_o.window_min = out_min_q;
  assign out_o.window_max = out_max_q;
  assign out_o.fill_level = out_fill_q;

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_fill_q <= MAX_CLIP_W))
    else $error("fill level exceeds the store depth");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_fill_q == '0)) |->
      ((out_newest_q == '0) && (out_min_q == '0) && (out_max_q == '0)))
    else $error("empty window reports nonzero values");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_min_q <= out_newest_q) && (out_newest_q <= out_max_q)))
    else $error("newest sample lies outside the reported range");

  a_issue_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue_q != '0) |-> (state_q == swmm_pkg::ST_SCAN))
    else $error("scan reads pending outside the scan state");
`endif

endmodule

// ===== dv/sliding_window_min_max_unit_test.sv =====
module sliding_window_min_max_unit_test;

  localparam int unsigned MAX_WIN     = 256;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_CYCLES = 500;

  typedef struct packed {
    logic signed [swmm_pkg::SAMPLE_W-1:0] newest;
    logic signed [swmm_pkg::SAMPLE_W-1:0] low;
    logic signed [swmm_pkg::SAMPLE_W-1:0] high;
    logic        [swmm_pkg::CNT_W-1:0]    fill;
  } range_word_t;

  typedef enum logic [1:0] {
    STEP_WORD,
    STEP_WINDOW,
    STEP_SETTLE
  } step_kind_e;

  typedef struct {
    step_kind_e                           kind;
    logic                                 func;
    logic signed [swmm_pkg::SAMPLE_W-1:0] sample;
    logic        [swmm_pkg::CNT_W-1:0]    size;
  } script_step_t;

  logic clk_i;
  logic rst_ni;

  swmm_cfg_if window_cfg ();
  swmm_in_if  word_in ();
  swmm_out_if range_out ();

  sliding_window_min_max_unit #(
    .MAX_WINDOW(MAX_WIN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (window_cfg),
    .in_i  (word_in),
    .out_o (range_out)
  );

  // Mirror of the window kept by the block.
  logic signed [swmm_pkg::SAMPLE_W-1:0] kept_samples [MAX_WIN];
  int unsigned                          head_slot  = 0;
  int unsigned                          kept_total = 0;
  int unsigned                          window_len = 0;

  range_word_t  range_due [$];
  script_step_t script [$];

  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  bit          word_taken   = 1'b0;
  bit          window_taken = 1'b0;
  int unsigned hold_left    = 0;
  bit          hold_used    = 1'b0;
  logic        steady;

  // Neither side idles while this stretch of results goes by.
  assign steady = (results_seen >= 500) && (results_seen < 800);

  task report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task check_field(input string name, input logic signed [31:0] got,
                   input logic signed [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task apply_window_size(input logic [swmm_pkg::CNT_W-1:0] size);
    int unsigned span;
    window_len = size;
    span = (window_len > MAX_WIN) ? MAX_WIN : window_len;
    if (kept_total > span) begin
      kept_total = span;
    end
  endtask

  task advance_window(input logic op, input logic signed [swmm_pkg::SAMPLE_W-1:0] value);
    range_word_t                          res;
    logic signed [swmm_pkg::SAMPLE_W-1:0] lo;
    logic signed [swmm_pkg::SAMPLE_W-1:0] hi;
    logic signed [swmm_pkg::SAMPLE_W-1:0] v;
    int unsigned                          span;
    res = '0;
    if (op == swmm_pkg::FUNC_CLEAR) begin
      kept_total = 0;
    end else begin
      span = (window_len > MAX_WIN) ? MAX_WIN : window_len;
      head_slot = (head_slot + 1) % MAX_WIN;
      kept_samples[head_slot] = value;
      kept_total = (kept_total + 1 > span) ? span : kept_total + 1;
      if (kept_total > 0) begin
        lo = value;
        hi = value;
        for (int unsigned k = 1; k < kept_total; k++) begin
          v = kept_samples[(head_slot + MAX_WIN - k) % MAX_WIN];
          if (v < lo) begin
            lo = v;
          end
          if (v > hi) begin
            hi = v;
          end
        end
        res.newest = value;
        res.low    = lo;
        res.high   = hi;
      end
    end
    res.fill = swmm_pkg::CNT_W'(kept_total);
    range_due.push_back(res);
  endtask

  function automatic logic signed [swmm_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return swmm_pkg::SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      default: return swmm_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task queue_word(input logic op, input logic signed [swmm_pkg::SAMPLE_W-1:0] value);
    script.push_back(script_step_t'{STEP_WORD, op, value, '0});
  endtask

  task queue_settle();
    script.push_back(script_step_t'{STEP_SETTLE, swmm_pkg::FUNC_ADD, '0, '0});
  endtask

  // The window size may only change once every word in flight has come back.
  task queue_window(input logic [swmm_pkg::CNT_W-1:0] size);
    queue_settle();
    script.push_back(script_step_t'{STEP_WINDOW, swmm_pkg::FUNC_ADD, '0, size});
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : bus_monitor
    range_word_t want;
    if (rst_ni) begin
      if (range_out.valid && range_out.ready) begin
        results_seen++;
        if (range_due.size() == 0) begin
          report_mismatch("result word with no expectation waiting");
        end else begin
          want = range_due.pop_front();
          check_field("newest", range_out.newest, want.newest);
          check_field("window_min", range_out.window_min, want.low);
          check_field("window_max", range_out.window_max, want.high);
          check_field("fill_level", range_out.fill_level, want.fill);
        end
      end
      if (word_in.valid && word_in.ready) begin
        advance_window(word_in.func, word_in.sample);
        word_taken = 1'b1;
      end
      if (window_cfg.valid && window_cfg.ready) begin
        apply_window_size(window_cfg.data);
        window_taken = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin : stimulus_driver
    logic offer_word;
    logic offer_cfg;
    logic took;
    offer_word = 1'b0;
    offer_cfg  = 1'b0;
    took       = word_taken;
    if (rst_ni) begin
      if (word_taken || window_taken) begin
        void'(script.pop_front());
        word_taken   = 1'b0;
        window_taken = 1'b0;
      end else if (script.size() > 0 && script[0].kind == STEP_SETTLE &&
                   range_due.size() == 0) begin
        void'(script.pop_front());
      end
      if (script.size() > 0) begin
        case (script[0].kind)
          STEP_WORD: begin
            // A word already offered stays offered until it is taken.
            offer_word = (word_in.valid && !took) || steady ||
                         ($urandom_range(0, 99) >= 26);
          end
          STEP_WINDOW: begin
            offer_cfg = 1'b1;
          end
          default: ;
        endcase
      end
    end
    word_in.valid    <= offer_word;
    window_cfg.valid <= offer_cfg;
    if (offer_word) begin
      word_in.func   <= script[0].func;
      word_in.sample <= script[0].sample;
    end
    if (offer_cfg) begin
      window_cfg.data <= script[0].size;
    end
  end

  // Once early in the run the sink stops taking results for a long stretch,
  // so the block fills up and holds off new words.
  always @(negedge clk_i) begin : result_sink
    if (!rst_ni) begin
      range_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      range_out.ready <= 1'b0;
    end else if (!hold_used && results_seen >= 200) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      range_out.ready <= 1'b0;
    end else begin
      range_out.ready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : test_sequence
    int unsigned phase_size [12];
    int unsigned phase_len [12];
    rst_ni = 1'b0;

    // Zero window straight after reset: the sample is stored but not kept.
    queue_word(swmm_pkg::FUNC_ADD, 16'sh7FFF);
    queue_word(swmm_pkg::FUNC_CLEAR, 16'sh1234);
    queue_window(3);
    queue_word(swmm_pkg::FUNC_ADD, 16'sh8000);
    queue_word(swmm_pkg::FUNC_ADD, 16'sh7FFF);
    queue_word(swmm_pkg::FUNC_ADD, 16'sh0000);
    queue_word(swmm_pkg::FUNC_ADD, 16'shFFFF);
    queue_word(swmm_pkg::FUNC_ADD, 16'sh0001);
    queue_word(swmm_pkg::FUNC_ADD, 16'sh0001);
    queue_word(swmm_pkg::FUNC_CLEAR, 16'sh7FFF);
    queue_word(swmm_pkg::FUNC_ADD, 16'sh0100);
    // A size past the store depth saturates.
    queue_window(511);
    queue_word(swmm_pkg::FUNC_ADD, 16'sd100);
    queue_word(swmm_pkg::FUNC_ADD, -16'sd100);
    // Shrinking the window drops the oldest samples at once.
    queue_window(2);
    queue_word(swmm_pkg::FUNC_ADD, 16'sd7);
    queue_window(0);
    queue_word(swmm_pkg::FUNC_ADD, 16'sd42);
    queue_word(swmm_pkg::FUNC_CLEAR, 16'sd0);

    phase_size = '{1, 2, 5, 16, 256, 511, 7, 64, 0, 33, 300, 3};
    phase_len  = '{120, 120, 150, 200, 300, 60, 150, 150, 60, 150, 40, 150};
    for (int p = 0; p < 12; p++) begin
      queue_window(swmm_pkg::CNT_W'(phase_size[p]));
      for (int n = 0; n < phase_len[p]; n++) begin
        // Clears stay out of windows at or past the store depth, so those are never emptied.
        if (phase_size[p] < MAX_WIN && $urandom_range(0, 29) == 0) begin
          queue_word(swmm_pkg::FUNC_CLEAR, swmm_pkg::SAMPLE_W'($urandom));
        end else begin
          queue_word(swmm_pkg::FUNC_ADD, pick_sample());
        end
        if ($urandom_range(0, 199) == 0) begin
          queue_settle();
        end
      end
    end
    queue_settle();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (script.size() == 0);
    wait (range_due.size() == 0);
    repeat (MAX_WIN + 16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
